// File: sv/mexp_pkg.sv
// Shared widths, constants and unit handshake types for the modular exponentiation block.
`default_nettype none

package mexp_pkg;

    // Field widths fixed by the interface
    localparam int BASE_FIELD_WIDTH = 63;
    localparam int EXP_FIELD_WIDTH  = 63;
    localparam int MOD_FIELD_WIDTH  = 31;
    localparam int RES_FIELD_WIDTH  = 31;

    // Bits of exponent and modulus actually used
    localparam int EXP_WIDTH = 63;
    localparam int MOD_WIDTH = 31;

    // Multiplier word: wide enough for the unreduced base
    localparam int WORD_WIDTH = BASE_FIELD_WIDTH;
    localparam int CNT_WIDTH  = $clog2(WORD_WIDTH + 1);

    localparam logic [MOD_WIDTH-1:0] RESET_MODULUS = MOD_WIDTH'(1000000007);
    localparam logic [MOD_WIDTH-1:0] ONE_MOD       = MOD_WIDTH'(1);

    localparam logic [CNT_WIDTH-1:0] LEN_REDUCE = CNT_WIDTH'(BASE_FIELD_WIDTH);
    localparam logic [CNT_WIDTH-1:0] LEN_MUL    = CNT_WIDTH'(MOD_WIDTH);

    // Request to the shared modular multiplier: x * y mod m, y scanned MSB first
    typedef struct packed {
        logic                  start;
        logic [MOD_WIDTH-1:0]  x;
        logic [WORD_WIDTH-1:0] y;
        logic [CNT_WIDTH-1:0]  len;
    } mexp_req_t;

    typedef struct packed {
        logic                 done;
        logic [MOD_WIDTH-1:0] product;
    } mexp_rsp_t;

endpackage

`default_nettype wire

// File: sv/mexp_mulmod.sv
// Bit-serial interleaved modular multiplier, one multiplier bit per cycle.
`default_nettype none

module mexp_mulmod
    import mexp_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic [MOD_WIDTH-1:0] m,
    input  wire mexp_req_t            req,
    output mexp_rsp_t                 rsp
);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_WIDTH-1:0]  cnt_reg, cnt_next;
    logic [MOD_WIDTH-1:0]  r_reg, r_next;
    logic [MOD_WIDTH-1:0]  x_reg, x_next;
    logic [WORD_WIDTH-1:0] y_reg, y_next;

    logic [MOD_WIDTH-1:0] addend;
    logic [MOD_WIDTH+1:0] sum;
    logic [MOD_WIDTH+1:0] m_ext;
    logic [MOD_WIDTH+1:0] s1;
    logic [MOD_WIDTH+1:0] s2;

    // r < m and addend <= m keep 2r + addend below 3m: two subtracts settle it
    always_comb
    begin
        addend = y_reg[WORD_WIDTH-1] ? x_reg : '0;
        m_ext  = {2'b00, m};
        sum    = {1'b0, r_reg, 1'b0} + {2'b00, addend};
        s1     = (sum >= m_ext) ? (sum - m_ext) : sum;
        s2     = (s1 >= m_ext) ? (s1 - m_ext) : s1;
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        r_next    = r_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = req.len;
            r_next    = '0;
            x_next    = req.x;
            y_next    = req.y;
        end
        else if (busy_reg)
        begin
            r_next   = s2[MOD_WIDTH-1:0];
            y_next   = {y_reg[WORD_WIDTH-2:0], 1'b0};
            cnt_next = cnt_reg - CNT_WIDTH'(1);
            if (cnt_reg == CNT_WIDTH'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg <= r_next;
        x_reg <= x_next;
        y_reg <= y_next;
    end

    assign rsp.done    = done_reg;
    assign rsp.product = r_reg;

    a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("multiplier started while busy");

    a_residue_below_m: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg || done_reg) |-> (r_reg < m))
        else $error("partial residue not reduced");

    a_done_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(busy_reg) && !busy_reg))
        else $error("done without a finished run");

endmodule

`default_nettype wire

// File: sv/modular_exponentiation.sv
// Top level: right-to-left square-and-multiply sequencer around a shared modular multiplier.
//
//   channel  | direction | handshake               | payload
//   ---------+-----------+-------------------------+--------------------------
//   in       | input     | in_valid / in_stall     | base_value[62:0], exponent[62:0]
//   out      | output    | out_valid / out_stall   | power_result[30:0]
//   cfg      | input     | cfg_wr_en               | cfg_wr_data[30:0] (modulus)
//
// The shared multiplier first reduces the base modulo the modulus, then runs the squares
// and multiplies, one per pass. A zero exponent or a modulus below two skips the multiplier
// and goes straight to S_FINISH. The next beat is taken once the sequencer is back in
// S_IDLE, after the result has been loaded into the output register.
// Reset loads the modulus 1000000007 and empties the output register. A finished result
// waits in the output register under out_stall while the next beat is already accepted.
`default_nettype none

module modular_exponentiation
    import mexp_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic [BASE_FIELD_WIDTH-1:0] base_value,
    input  wire logic [EXP_FIELD_WIDTH-1:0]  exponent,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic [RES_FIELD_WIDTH-1:0]      power_result,
    input  wire logic                       cfg_wr_en,
    input  wire logic [MOD_FIELD_WIDTH-1:0] cfg_wr_data
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_REDUCE = 6'b000010,
        S_NEXT   = 6'b000100,
        S_MUL    = 6'b001000,
        S_SQR    = 6'b010000,
        S_FINISH = 6'b100000
    } state_t;

    state_t                state_reg, state_next;
    logic [MOD_WIDTH-1:0]  modulus_reg;
    logic [EXP_WIDTH-1:0]  e_reg, e_next;
    logic [MOD_WIDTH-1:0]  acc_reg, acc_next;
    logic [MOD_WIDTH-1:0]  b_reg, b_next;
    logic                  out_valid_reg, out_valid_next;
    logic [MOD_WIDTH-1:0]  res_reg, res_next;

    mexp_req_t req;
    mexp_rsp_t rsp;
    logic      in_beat;
    logic      e_rest_zero;

    assign in_beat     = in_valid && (state_reg == S_IDLE);
    assign e_rest_zero = (e_reg[EXP_WIDTH-1:1] == '0);

    mexp_mulmod u_mulmod (
        .clk   (clk),
        .rst_n (rst_n),
        .m     (modulus_reg),
        .req   (req),
        .rsp   (rsp)
    );

    always_comb
    begin
        state_next     = state_reg;
        e_next         = e_reg;
        acc_next       = acc_reg;
        b_next         = b_reg;
        out_valid_next = out_valid_reg;
        res_next       = res_reg;
        req.start      = 1'b0;
        req.x          = b_reg;
        req.y          = {b_reg, {(WORD_WIDTH - MOD_WIDTH){1'b0}}};
        req.len        = LEN_MUL;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    e_next = exponent[EXP_WIDTH-1:0];
                    if (exponent[EXP_WIDTH-1:0] == '0)
                    begin
                        acc_next   = ONE_MOD;
                        state_next = S_FINISH;
                    end
                    else if (modulus_reg <= ONE_MOD)
                    begin
                        acc_next   = '0;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        // base mod m: shift the base in one bit per cycle
                        req.start  = 1'b1;
                        req.x      = ONE_MOD;
                        req.y      = base_value;
                        req.len    = LEN_REDUCE;
                        state_next = S_REDUCE;
                    end
                end
            end
            S_REDUCE:
            begin
                if (rsp.done)
                begin
                    b_next     = rsp.product;
                    acc_next   = ONE_MOD;
                    state_next = S_NEXT;
                end
            end
            S_NEXT:
            begin
                if (e_reg == '0)
                begin
                    state_next = S_FINISH;
                end
                else if (e_reg[0])
                begin
                    req.start  = 1'b1;
                    req.x      = acc_reg;
                    state_next = S_MUL;
                end
                else
                begin
                    req.start  = 1'b1;
                    state_next = S_SQR;
                end
            end
            S_MUL:
            begin
                if (rsp.done)
                begin
                    acc_next = rsp.product;
                    // skip the square after the top set bit
                    if (e_rest_zero)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        req.start  = 1'b1;
                        state_next = S_SQR;
                    end
                end
            end
            S_SQR:
            begin
                if (rsp.done)
                begin
                    b_next     = rsp.product;
                    e_next     = {1'b0, e_reg[EXP_WIDTH-1:1]};
                    state_next = S_NEXT;
                end
            end
            S_FINISH:
            begin
                // hold until the output register is free or drains this cycle
                if (!out_valid_reg || !out_stall)
                begin
                    res_next       = acc_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            modulus_reg   <= RESET_MODULUS;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                modulus_reg <= cfg_wr_data[MOD_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        e_reg   <= e_next;
        acc_reg <= acc_next;
        b_reg   <= b_next;
        res_reg <= res_next;
    end

    assign in_stall     = (state_reg != S_IDLE);
    assign out_valid    = out_valid_reg;
    assign power_result = RES_FIELD_WIDTH'(res_reg);

    a_done_while_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done |-> (state_reg == S_REDUCE || state_reg == S_MUL || state_reg == S_SQR))
        else $error("multiplier result arrived outside a wait state");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !$past(out_valid_reg)) |-> $past(state_reg == S_FINISH))
        else $error("result loaded outside finish");

    a_start_from_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (req.start && state_reg == S_IDLE) |-> in_beat)
        else $error("multiplier started from idle without an input beat");

endmodule

`default_nettype wire

// File: tb/modular_exponentiation_tb.sv
// Self-checking testbench for the modular exponentiation block: directed table, then random phases.
`default_nettype none

module modular_exponentiation_tb
    import mexp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    typedef enum bit {ROW_ITEM, ROW_MODULUS} row_kind_t;

    typedef struct packed {
        row_kind_t                   kind;
        logic [MOD_FIELD_WIDTH-1:0]  modulus;
        logic [BASE_FIELD_WIDTH-1:0] base;
        logic [EXP_FIELD_WIDTH-1:0]  power;
        bit                          known;
        logic [RES_FIELD_WIDTH-1:0]  answer;
    } plan_row_t;

    localparam logic [BASE_FIELD_WIDTH-1:0] BASE_ALL = {BASE_FIELD_WIDTH{1'b1}};
    localparam logic [EXP_FIELD_WIDTH-1:0]  EXP_ALL  = {EXP_FIELD_WIDTH{1'b1}};
    localparam logic [MOD_FIELD_WIDTH-1:0]  MOD_ALL  = {MOD_FIELD_WIDTH{1'b1}};
    localparam int PLAN_ROWS      = 24;
    localparam int PHASE_ITEMS    = 30;
    localparam int HOLD_OFF_CYCLES = 10000;
    localparam int SETTLE_CYCLES  = 40;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        in_valid = 1'b0;
    logic                        in_stall;
    logic [BASE_FIELD_WIDTH-1:0] base_value = '0;
    logic [EXP_FIELD_WIDTH-1:0]  exponent = '0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic [RES_FIELD_WIDTH-1:0]  power_result;
    logic                        cfg_wr_en = 1'b0;
    logic [MOD_FIELD_WIDTH-1:0]  cfg_wr_data = '0;

    logic [RES_FIELD_WIDTH-1:0]  due_powers [$];
    logic [RES_FIELD_WIDTH-1:0]  due_now;
    logic [MOD_FIELD_WIDTH-1:0]  cur_modulus;
    int                          mismatch_count = 0;
    int                          send_idle = 0;
    int                          recv_idle = 0;
    int                          hold_left = 0;

    plan_row_t plan [PLAN_ROWS] = '{
        '{ROW_ITEM,    31'd0, 63'd0,          63'd0,          1'b1, 31'd1},
        '{ROW_ITEM,    31'd0, BASE_ALL,       63'd0,          1'b1, 31'd1},
        '{ROW_ITEM,    31'd0, 63'd0,          63'd5,          1'b1, 31'd0},
        '{ROW_ITEM,    31'd0, 63'd2,          63'd10,         1'b1, 31'd1024},
        '{ROW_ITEM,    31'd0, 63'd7,          63'd1,          1'b1, 31'd7},
        '{ROW_ITEM,    31'd0, 63'd1000000007, 63'd3,          1'b1, 31'd0},
        '{ROW_ITEM,    31'd0, BASE_ALL,       EXP_ALL,        1'b0, 31'd0},
        '{ROW_ITEM,    31'd0, 63'd3,          63'd1000000006, 1'b1, 31'd1},
        // modulus one: anything but a zero exponent collapses to zero
        '{ROW_MODULUS, 31'd1, 63'd0,          63'd0,          1'b0, 31'd0},
        '{ROW_ITEM,    31'd0, 63'd5,          63'd0,          1'b1, 31'd1},
        '{ROW_ITEM,    31'd0, 63'd5,          63'd7,          1'b1, 31'd0},
        '{ROW_ITEM,    31'd0, BASE_ALL,       EXP_ALL,        1'b1, 31'd0},
        // modulus zero lies outside the legal range but the port allows it
        '{ROW_MODULUS, 31'd0, 63'd0,          63'd0,          1'b0, 31'd0},
        '{ROW_ITEM,    31'd0, 63'd9,          63'd0,          1'b1, 31'd1},
        '{ROW_ITEM,    31'd0, 63'd9,          63'd3,          1'b1, 31'd0},
        '{ROW_ITEM,    31'd0, BASE_ALL,       63'd1,          1'b1, 31'd0},
        '{ROW_MODULUS, MOD_ALL, 63'd0,        63'd0,          1'b0, 31'd0},
        '{ROW_ITEM,    31'd0, 63'd2147483646, 63'd2,          1'b1, 31'd1},
        '{ROW_ITEM,    31'd0, 63'd2147483647, 63'd5,          1'b1, 31'd0},
        '{ROW_ITEM,    31'd0, BASE_ALL,       EXP_ALL,        1'b0, 31'd0},
        '{ROW_ITEM,    31'd0, 63'd2,          63'd31,         1'b1, 31'd1},
        '{ROW_MODULUS, 31'd2, 63'd0,          63'd0,          1'b0, 31'd0},
        '{ROW_ITEM,    31'd0, 63'd3,          EXP_ALL,        1'b1, 31'd1},
        '{ROW_ITEM,    31'd0, 63'd4,          63'd1,          1'b1, 31'd0}
    };

    modular_exponentiation dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .base_value   (base_value),
        .exponent     (exponent),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .power_result (power_result),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        #25ms;
        $display("tb: failure");
        $finish;
    end

    // right-to-left square-and-multiply; both factors stay below 2^31, so 64 bits suffice
    function automatic logic [RES_FIELD_WIDTH-1:0] expected_power(
        input logic [BASE_FIELD_WIDTH-1:0] b,
        input logic [EXP_FIELD_WIDTH-1:0]  e,
        input logic [MOD_FIELD_WIDTH-1:0]  m
    );
        logic [63:0]                m64;
        logic [63:0]                acc;
        logic [63:0]                sq;
        logic [EXP_FIELD_WIDTH-1:0] rest;
        if (e == '0)
            return RES_FIELD_WIDTH'(1);
        if (m == '0)
            return '0;
        m64  = 64'(m);
        sq   = 64'(b) % m64;
        acc  = 64'd1 % m64;
        rest = e;
        while (rest != '0)
        begin
            if (rest[0])
                acc = (acc * sq) % m64;
            sq   = (sq * sq) % m64;
            rest = rest >> 1;
        end
        return acc[RES_FIELD_WIDTH-1:0];
    endfunction

    // offer one beat, hold it until taken, then queue its answer
    task automatic send_power(
        input logic [BASE_FIELD_WIDTH-1:0] b,
        input logic [EXP_FIELD_WIDTH-1:0]  e,
        input bit                          known,
        input logic [RES_FIELD_WIDTH-1:0]  answer
    );
        if ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle);
        end
        base_value <= b;
        exponent   <= e;
        in_valid   <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        due_powers = {due_powers, (known ? answer : expected_power(b, e, cur_modulus))};
    endtask

    // drain all results so the block is idle, then load a new modulus
    task automatic write_modulus(input logic [MOD_FIELD_WIDTH-1:0] value);
        in_valid <= 1'b0;
        while (due_powers.size() != 0)
            @(posedge clk);
        cfg_wr_data <= value;
        cfg_wr_en   <= 1'b1;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        cur_modulus = value;
    endtask

    function automatic logic [EXP_FIELD_WIDTH-1:0] random_exponent();
        logic [63:0] raw;
        int          pick;
        int          bits;
        raw  = {$urandom, $urandom};
        pick = $urandom_range(99);
        if (pick < 5)
            return '0;
        if (pick < 13)
            return raw[EXP_FIELD_WIDTH-1:0];
        // keep most exponents short: run time grows with bit length
        bits = (pick < 23) ? $urandom_range(17, 40) : $urandom_range(1, 16);
        return raw[EXP_FIELD_WIDTH-1:0] & ((EXP_FIELD_WIDTH'(1) << bits) - 1'b1);
    endfunction

    function automatic logic [BASE_FIELD_WIDTH-1:0] random_base();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        if ($urandom_range(3) == 0)
            return BASE_FIELD_WIDTH'($urandom_range(0, 1000));
        return raw[BASE_FIELD_WIDTH-1:0];
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (due_powers.size() == 0)
            begin
                $display("%0t: unexpected beat, expected none, actual power_result %0d",
                         $time, power_result);
                mismatch_count++;
            end
            else
            begin
                due_now = due_powers.pop_front();
                if (power_result !== due_now)
                begin
                    $display("%0t: power_result mismatch, expected %0d, actual %0d",
                             $time, due_now, power_result);
                    mismatch_count++;
                end
            end
        end
        if (hold_left > 0)
            hold_left = hold_left - 1;
        out_stall <= (hold_left > 0) || ($urandom_range(99) < recv_idle);
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        cur_modulus = RESET_MODULUS;
        @(posedge clk);

        for (int i = 0; i < PLAN_ROWS; i++)
        begin
            if (plan[i].kind == ROW_MODULUS)
                write_modulus(plan[i].modulus);
            else
                send_power(plan[i].base, plan[i].power, plan[i].known, plan[i].answer);
        end

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    write_modulus(MOD_FIELD_WIDTH'($urandom_range(32'h4000_0000, 32'h7fff_ffff)));
                    send_idle = 27;
                    recv_idle = 83;
                end
                1:
                begin
                    write_modulus(MOD_FIELD_WIDTH'($urandom_range(3, 255)));
                    send_idle = 83;
                    recv_idle = 27;
                end
                2:
                begin
                    write_modulus(MOD_ALL);
                    send_idle = 0;
                    recv_idle = 0;
                    // stall the output long enough for the block to back up
                    hold_left = HOLD_OFF_CYCLES;
                end
                default:
                begin
                    write_modulus(MOD_FIELD_WIDTH'($urandom_range(1, 32'h7fff_ffff)));
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase
            repeat (PHASE_ITEMS)
                send_power(random_base(), random_exponent(), 1'b0, '0);
        end

        in_valid <= 1'b0;
        while (due_powers.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && due_powers.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire
